// ===== hw/rtl/tlp_pkg.sv =====
// shared types and character constants for the target/laser line parser
package tlp_pkg;

  localparam int MAX_LINE_DEF = 127;
  localparam int VAL_W        = 16;
  localparam int NUM_PARTS    = 2;
  localparam int NUM_FIELDS   = 3;

  localparam logic [VAL_W-1:0] SAT_MAG = 16'h8000;
  localparam logic [VAL_W-1:0] POS_MAX = 16'h7FFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_T     = 8'h54;

  // where we are inside one ';' part
  typedef enum logic [1:0] {
    PFX_LETTER = 2'd0,
    PFX_COLON  = 2'd1,
    PFX_FIELDS = 2'd2,
    PFX_SKIP   = 2'd3
  } prefix_t;

  // atoi progress of the open token
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BLANK  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
           (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== hw/rtl/target_laser_line_parser.sv =====
// target/laser line parser: byte stream in, one parsed record per newline out
//
// usage
//   input channel: one received uart byte per beat (in_valid/in_ready/in_rx_byte)
//   output channel: one record per newline byte (out_valid/out_ready and payload):
//     out_parse_ok plus the six stored values after the line was committed
//   every byte is consumed in the cycle it is accepted; a record appears on the
//     output in the cycle after its newline beat and holds until taken
//   throughput: one byte per cycle, set by the single state-update stage; the
//     output register frees itself in the same cycle it is taken, so a newline
//     can be accepted while the previous record is being read
//   stall: while a record waits with out_ready low, in_ready is low
//   reset (rst_n low, synchronous): stored values zero, line state cleared,
//     no record pending
//   a byte that would bring a line to MAX_LINE bytes drops the line so far with no
//     record; parsing restarts after it and the next newline still gives a record
//   a nul byte freezes parsing until the newline, bytes still count toward length
module target_laser_line_parser
  import tlp_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_parse_ok,
  output logic signed [VAL_W-1:0] out_target_x,
  output logic signed [VAL_W-1:0] out_target_y,
  output logic signed [VAL_W-1:0] out_target_status,
  output logic signed [VAL_W-1:0] out_laser_x,
  output logic signed [VAL_W-1:0] out_laser_y,
  output logic signed [VAL_W-1:0] out_laser_status
);

  // line length counter only has to reach MAX_LINE-1
  localparam int LenW = $clog2(MAX_LINE + 1);
  localparam logic [LenW-1:0] LenLimit = LenW'(MAX_LINE - 1);

  // stored (committed) values
  logic [VAL_W-1:0] tgt_r [NUM_FIELDS];
  logic [VAL_W-1:0] tgt_nxt [NUM_FIELDS];
  logic [VAL_W-1:0] lsr_r [NUM_FIELDS];
  logic [VAL_W-1:0] lsr_nxt [NUM_FIELDS];

  // per-line pending fields, committed at the newline
  logic [VAL_W-1:0] pend_val_r [NUM_PARTS][NUM_FIELDS];
  logic [VAL_W-1:0] pend_val_nxt [NUM_PARTS][NUM_FIELDS];
  logic             pend_ok_r [NUM_PARTS][NUM_FIELDS];
  logic             pend_ok_nxt [NUM_PARTS][NUM_FIELDS];

  // line parse state
  logic [1:0]       part_idx_r, part_idx_nxt;
  logic             part_open_r, part_open_nxt;
  prefix_t          prefix_r, prefix_nxt;
  logic [1:0]       field_idx_r, field_idx_nxt;
  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [LenW-1:0]  line_len_r, line_len_nxt;
  logic             ended_r, ended_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [VAL_W-1:0] out_tgt_r [NUM_FIELDS];
  logic [VAL_W-1:0] out_lsr_r [NUM_FIELDS];

  // combinational helpers
  logic             in_fire;
  logic             tok_end;
  logic             tok_store;
  logic             tok_part;
  logic [VAL_W-1:0] tok_val;
  logic             line_ok;
  logic             line_clear;
  logic [1:0]       part_new;
  phase_t           fc_phase;
  logic             fc_neg;
  logic [VAL_W-1:0] fc_acc;
  logic             fc_sign;
  logic [VAL_W+2:0] fc_prod;

  // the output register empties in the cycle it is taken
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // value of the open token by atoi rules, saturated to 16 bits
  always_comb begin
    if (neg_r) begin
      tok_val = ~acc_r + VAL_W'(1);
    end else if (acc_r > POS_MAX) begin
      tok_val = POS_MAX;
    end else begin
      tok_val = acc_r;
    end
  end

  // part_index saturates at three
  assign part_new = (part_idx_r == 2'd3) ? 2'd3 : part_idx_r + 2'd1;

  // per-byte next state
  always_comb begin
    tgt_nxt       = tgt_r;
    lsr_nxt       = lsr_r;
    pend_val_nxt  = pend_val_r;
    pend_ok_nxt   = pend_ok_r;
    part_idx_nxt  = part_idx_r;
    part_open_nxt = part_open_r;
    prefix_nxt    = prefix_r;
    field_idx_nxt = field_idx_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    line_len_nxt  = line_len_r;
    ended_nxt     = ended_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    tok_end       = 1'b0;
    line_ok       = 1'b0;
    line_clear    = 1'b0;
    fc_phase      = phase_r;
    fc_neg        = neg_r;
    fc_acc        = acc_r;
    fc_sign       = 1'b0;
    fc_prod       = '0;

    if (in_fire) begin
      if (in_rx_byte == CH_NL) begin
        tok_end = part_open_r && (prefix_r == PFX_FIELDS);
      end else if (line_len_r >= LenLimit) begin
        line_clear = 1'b1;
      end else begin
        line_len_nxt = line_len_r + LenW'(1);
        if (!ended_r) begin
          if (in_rx_byte == CH_NUL) begin
            ended_nxt = 1'b1;
          end else if (in_rx_byte == CH_SEMI) begin
            if (part_open_r) begin
              tok_end       = (prefix_r == PFX_FIELDS);
              part_open_nxt = 1'b0;
            end
          end else if (!part_open_r) begin
            // first byte of a new part is its prefix letter
            part_open_nxt = 1'b1;
            part_idx_nxt  = part_new;
            field_idx_nxt = 2'd0;
            phase_nxt     = PH_IDLE;
            if (part_new == 2'd1) begin
              prefix_nxt = (in_rx_byte == CH_T) ? PFX_COLON : PFX_SKIP;
            end else if (part_new == 2'd2) begin
              prefix_nxt = (in_rx_byte == CH_L) ? PFX_COLON : PFX_SKIP;
            end else begin
              prefix_nxt = PFX_SKIP;
            end
          end else begin
            unique case (prefix_r)
              PFX_LETTER: begin
                if (part_idx_r == 2'd1) begin
                  prefix_nxt = (in_rx_byte == CH_T) ? PFX_COLON : PFX_SKIP;
                end else begin
                  prefix_nxt = (in_rx_byte == CH_L) ? PFX_COLON : PFX_SKIP;
                end
              end
              PFX_COLON: begin
                prefix_nxt = (in_rx_byte == CH_COLON) ? PFX_FIELDS : PFX_SKIP;
              end
              PFX_FIELDS: begin
                if (in_rx_byte == CH_COMMA) begin
                  tok_end = 1'b1;
                end else begin
                  if (fc_phase == PH_IDLE) begin
                    fc_phase = PH_BLANK;
                    fc_neg   = 1'b0;
                    fc_acc   = '0;
                  end
                  if (fc_phase == PH_BLANK) begin
                    if (is_blank(in_rx_byte)) begin
                      fc_phase = PH_BLANK;
                    end else if (in_rx_byte == CH_PLUS || in_rx_byte == CH_MINUS) begin
                      fc_neg   = (in_rx_byte == CH_MINUS);
                      fc_phase = PH_DIGITS;
                      fc_sign  = 1'b1;
                    end else if (is_digit(in_rx_byte)) begin
                      fc_phase = PH_DIGITS;
                    end else begin
                      fc_phase = PH_DONE;
                    end
                  end
                  if (fc_phase == PH_DIGITS && !fc_sign) begin
                    if (is_digit(in_rx_byte)) begin
                      fc_prod = ({3'b000, fc_acc} << 3) + ({3'b000, fc_acc} << 1) +
                                (VAL_W + 3)'(in_rx_byte[3:0]);
                      fc_acc  = (fc_prod > (VAL_W + 3)'(SAT_MAG)) ? SAT_MAG
                                                                  : fc_prod[VAL_W-1:0];
                    end else begin
                      fc_phase = PH_DONE;
                    end
                  end
                  phase_nxt = fc_phase;
                  neg_nxt   = fc_neg;
                  acc_nxt   = fc_acc;
                end
              end
              PFX_SKIP: begin
                prefix_nxt = PFX_SKIP;
              end
              default: begin
                prefix_nxt = PFX_SKIP;
              end
            endcase
          end
        end
      end
    end

    // close the open token: keep it if it belongs to a wanted field
    if (tok_end && phase_r != PH_IDLE) begin
      for (int p = 0; p < NUM_PARTS; p++) begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (tok_store && (tok_part == p[0]) && (field_idx_r == i[1:0])) begin
            pend_val_nxt[p][i] = tok_val;
            pend_ok_nxt[p][i]  = 1'b1;
          end
        end
      end
      field_idx_nxt = (field_idx_r == 2'd3) ? 2'd3 : field_idx_r + 2'd1;
      phase_nxt     = PH_IDLE;
    end

    // newline: commit when both parts were seen, then emit the record
    if (in_fire && in_rx_byte == CH_NL) begin
      line_ok = (part_idx_r >= 2'd2);
      for (int i = 0; i < NUM_FIELDS; i++) begin
        if (line_ok && pend_ok_nxt[0][i]) begin
          tgt_nxt[i] = pend_val_nxt[0][i];
        end
        if (line_ok && pend_ok_nxt[1][i]) begin
          lsr_nxt[i] = pend_val_nxt[1][i];
        end
      end
      out_valid_nxt = 1'b1;
      out_ok_nxt    = line_ok;
      line_clear    = 1'b1;
    end

    if (line_clear) begin
      part_idx_nxt  = 2'd0;
      part_open_nxt = 1'b0;
      prefix_nxt    = PFX_LETTER;
      field_idx_nxt = 2'd0;
      phase_nxt     = PH_IDLE;
      neg_nxt       = 1'b0;
      acc_nxt       = '0;
      line_len_nxt  = '0;
      ended_nxt     = 1'b0;
      for (int p = 0; p < NUM_PARTS; p++) begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
          pend_ok_nxt[p][i] = 1'b0;
        end
      end
    end
  end

  // token lands in part one or two, first three fields only
  assign tok_store = (part_idx_r == 2'd1 || part_idx_r == 2'd2) && (field_idx_r != 2'd3);
  assign tok_part  = (part_idx_r == 2'd2);

  // control and stored state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_idx_r  <= 2'd0;
      part_open_r <= 1'b0;
      prefix_r    <= PFX_LETTER;
      field_idx_r <= 2'd0;
      phase_r     <= PH_IDLE;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      line_len_r  <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        tgt_r[i] <= '0;
        lsr_r[i] <= '0;
      end
      for (int p = 0; p < NUM_PARTS; p++) begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
          pend_ok_r[p][i] <= 1'b0;
        end
      end
    end else begin
      part_idx_r  <= part_idx_nxt;
      part_open_r <= part_open_nxt;
      prefix_r    <= prefix_nxt;
      field_idx_r <= field_idx_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      line_len_r  <= line_len_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
      tgt_r       <= tgt_nxt;
      lsr_r       <= lsr_nxt;
      pend_ok_r   <= pend_ok_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    out_ok_r   <= out_ok_nxt;
    if (in_fire && in_rx_byte == CH_NL) begin
      out_tgt_r <= tgt_nxt;
      out_lsr_r <= lsr_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_parse_ok      = out_ok_r;
  assign out_target_x      = $signed(out_tgt_r[0]);
  assign out_target_y      = $signed(out_tgt_r[1]);
  assign out_target_status = $signed(out_tgt_r[2]);
  assign out_laser_x       = $signed(out_lsr_r[0]);
  assign out_laser_y       = $signed(out_lsr_r[1]);
  assign out_laser_status  = $signed(out_lsr_r[2]);

  // a token can only be open inside a part whose prefix matched
  a_token_in_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (part_open_r && prefix_r == PFX_FIELDS))
    else $error("token open outside a field section");

  // the prefix letter is only awaited between parts
  a_letter_closed: assert property (@(posedge clk) disable iff (!rst_n)
    part_open_r |-> (prefix_r != PFX_LETTER))
    else $error("open part still waiting for its letter");

  // line length never passes the drop limit
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= LenLimit)
    else $error("line length past limit");

  // a new record only follows a newline beat
  a_rec_from_nl: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && in_ready && in_rx_byte == CH_NL))
    else $error("record without newline");

endmodule

// ===== tb/sv/tlp_line_checker.sv =====
`timescale 1ns / 100ps
// record checker for the target/laser line parser: predicts each record from the byte beats
module tlp_line_checker
  import tlp_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [7:0]              in_rx_byte,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_parse_ok,
  input  logic signed [VAL_W-1:0] out_target_x,
  input  logic signed [VAL_W-1:0] out_target_y,
  input  logic signed [VAL_W-1:0] out_target_status,
  input  logic signed [VAL_W-1:0] out_laser_x,
  input  logic signed [VAL_W-1:0] out_laser_y,
  input  logic signed [VAL_W-1:0] out_laser_status,
  output int unsigned             records_owed,
  output int unsigned             mismatch_count
);

  // field 0 is parse_ok, then target x/y/status, then laser x/y/status
  typedef struct {
    int field[7];
  } line_record_t;

  string field_name[7] = '{"parse_ok", "target_x", "target_y", "target_status",
                           "laser_x", "laser_y", "laser_status"};

  line_record_t owed_records[$];

  shortint      kept_target[3];
  shortint      kept_laser[3];
  shortint      pend_val[2][3];
  bit           pend_ok[2][3];
  int unsigned  parts_seen;
  int unsigned  tok_count;
  int unsigned  line_len;
  int unsigned  mag;
  bit           in_part;
  bit           neg;
  bit           nul_seen;
  prefix_t      prefix;
  phase_t       phase;

  initial begin
    records_owed   = 0;
    mismatch_count = 0;
  end

  function automatic void clear_line_state();
    parts_seen = 0;
    tok_count  = 0;
    line_len   = 0;
    mag        = 0;
    in_part    = 1'b0;
    neg        = 1'b0;
    nul_seen   = 1'b0;
    prefix     = PFX_LETTER;
    phase      = PH_IDLE;
    for (int p = 0; p < 2; p++) begin
      for (int f = 0; f < 3; f++) begin
        pend_val[p][f] = 0;
        pend_ok[p][f]  = 1'b0;
      end
    end
  endfunction

  // finish the open token and park its value until the newline
  function automatic void close_token();
    shortint v;
    if (phase == PH_IDLE) return;
    if (neg) v = shortint'(-int'(mag));
    else v = (mag > 32767) ? shortint'(32767) : shortint'(mag);
    if (parts_seen >= 1 && parts_seen <= 2 && prefix == PFX_FIELDS && tok_count < 3) begin
      pend_val[parts_seen-1][tok_count] = v;
      pend_ok[parts_seen-1][tok_count]  = 1'b1;
    end
    if (tok_count < 3) tok_count++;
    phase = PH_IDLE;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] c);
    line_record_t rec;
    bit           ok;
    if (c == CH_NL) begin
      if (in_part && prefix == PFX_FIELDS) close_token();
      ok = (parts_seen >= 2);
      rec.field[0] = int'(ok);
      for (int i = 0; i < 3; i++) begin
        if (ok && pend_ok[0][i]) kept_target[i] = pend_val[0][i];
        if (ok && pend_ok[1][i]) kept_laser[i] = pend_val[1][i];
        rec.field[1+i] = kept_target[i];
        rec.field[4+i] = kept_laser[i];
      end
      owed_records.push_back(rec);
      clear_line_state();
      return;
    end
    // overlong line: drop it, this byte included
    if (line_len + 1 >= MAX_LINE) begin
      clear_line_state();
      return;
    end
    line_len++;
    if (nul_seen) return;
    if (c == CH_NUL) begin
      nul_seen = 1'b1;
      return;
    end
    if (c == CH_SEMI) begin
      if (in_part && prefix == PFX_FIELDS) close_token();
      in_part = 1'b0;
      return;
    end
    if (!in_part) begin
      in_part = 1'b1;
      if (parts_seen < 3) parts_seen++;
      tok_count = 0;
      phase     = PH_IDLE;
      prefix    = (parts_seen <= 2) ? PFX_LETTER : PFX_SKIP;
    end
    case (prefix)
      PFX_LETTER: begin
        prefix = (c == ((parts_seen == 1) ? CH_T : CH_L)) ? PFX_COLON : PFX_SKIP;
      end
      PFX_COLON: begin
        prefix = (c == CH_COLON) ? PFX_FIELDS : PFX_SKIP;
      end
      PFX_FIELDS: begin
        if (c == CH_COMMA) begin
          close_token();
        end else begin
          if (phase == PH_IDLE) begin
            phase = PH_BLANK;
            neg   = 1'b0;
            mag   = 0;
          end
          if (phase == PH_BLANK) begin
            if (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR}) begin
              // still skipping blanks
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              neg   = (c == CH_MINUS);
              phase = PH_DIGITS;
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
              phase = PH_DIGITS;
              mag   = int'(c - CH_ZERO);
            end else begin
              phase = PH_DONE;
            end
          end else if (phase == PH_DIGITS) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              mag = mag * 10 + int'(c - CH_ZERO);
              if (mag > 32768) mag = 32768;
            end else begin
              phase = PH_DONE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    line_record_t want;
    int           got[7];
    if (!rst_n) begin
      owed_records.delete();
      for (int i = 0; i < 3; i++) begin
        kept_target[i] = 0;
        kept_laser[i]  = 0;
      end
      clear_line_state();
    end else begin
      // a record leaves no earlier than the cycle after its newline, so compare first
      if (out_valid && out_ready) begin
        got = '{int'(out_parse_ok), int'(out_target_x), int'(out_target_y),
                int'(out_target_status), int'(out_laser_x), int'(out_laser_y),
                int'(out_laser_status)};
        if (owed_records.size() == 0) begin
          if (mismatch_count < 10)
            $display("record beat with none owed: parse_ok %0d target_x %0d laser_x %0d",
                     got[0], got[1], got[4]);
          mismatch_count++;
        end else begin
          want = owed_records.pop_front();
          for (int i = 0; i < 7; i++) begin
            if (got[i] != want.field[i]) begin
              if (mismatch_count < 10)
                $display("%s mismatch: expected %0d, got %0d", field_name[i],
                         want.field[i], got[i]);
              mismatch_count++;
            end
          end
        end
      end
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
    end
    records_owed = owed_records.size();
  end

endmodule

// ===== tb/sv/target_laser_line_parser_test.sv =====
`timescale 1ns / 100ps
// top level of the line parser bench: byte stimulus, record sink, reset and verdict
module target_laser_line_parser_test;
  import tlp_pkg::*;

  // stop generating once this many random byte beats went in
  localparam int RANDOM_BYTES = 1050;
  // far beyond the slowest legal run (every stimulus byte, the longest gaps and stalls)
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic [7:0]              in_rx_byte = 8'h00;
  logic                    in_ready;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic                    out_parse_ok;
  logic signed [VAL_W-1:0] out_target_x;
  logic signed [VAL_W-1:0] out_target_y;
  logic signed [VAL_W-1:0] out_target_status;
  logic signed [VAL_W-1:0] out_laser_x;
  logic signed [VAL_W-1:0] out_laser_y;
  logic signed [VAL_W-1:0] out_laser_status;

  int unsigned records_owed;
  int unsigned mismatch_count;

  // text of the line being built, newline appended on send
  logic [7:0]  line_buf[$];
  logic [7:0]  blank_set[5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
  int unsigned sent_bytes  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_pct   = 0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  target_laser_line_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_parse_ok      (out_parse_ok),
    .out_target_x      (out_target_x),
    .out_target_y      (out_target_y),
    .out_target_status (out_target_status),
    .out_laser_x       (out_laser_x),
    .out_laser_y       (out_laser_y),
    .out_laser_status  (out_laser_status)
  );

  tlp_line_checker u_line_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_parse_ok      (out_parse_ok),
    .out_target_x      (out_target_x),
    .out_target_y      (out_target_y),
    .out_target_status (out_target_status),
    .out_laser_x       (out_laser_x),
    .out_laser_y       (out_laser_y),
    .out_laser_status  (out_laser_status),
    .records_owed      (records_owed),
    .mismatch_count    (mismatch_count)
  );

  // idle length: drawn from three ranges, the shortest most often, a long pause rarely
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // how many comma fields a part gets: three most of the time
  function automatic int unsigned field_total();
    return ($urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 4);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    line_buf.push_back(b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_fill(input logic [7:0] b, input int unsigned n);
    repeat (n) line_buf.push_back(b);
  endtask

  // one atoi token: optional blanks and sign, a number of random size, rare junk after
  task automatic put_field();
    int unsigned pick;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) put_byte(blank_set[$urandom_range(0, 4)]);
    pick = $urandom_range(0, 9);
    if (pick < 2) put_byte(CH_MINUS);
    else if (pick == 2) put_byte(CH_PLUS);
    pick = $urandom_range(0, 19);
    if (pick < 11) put_str($sformatf("%0d", $urandom_range(0, 999)));
    else if (pick < 15) put_str($sformatf("%0d", $urandom_range(1000, 32768)));
    else if (pick < 17) put_str($sformatf("%0d", $urandom_range(32769, 9999999)));
    else if (pick < 19) put_str($sformatf("00%0d", $urandom_range(0, 99)));
    // pick 19 leaves the token without digits
    if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(32, 126)));
  endtask

  // tag then comma separated fields, with occasional separator runs
  task automatic put_part(input string tag, input int unsigned fields);
    put_str(tag);
    for (int i = 0; i < fields; i++) begin
      if (i != 0)
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1) put_byte(CH_COMMA);
      put_field();
    end
    if ($urandom_range(0, 9) == 0) put_byte(CH_COMMA);
  endtask

  // push the line plus newline one beat at a time; some lines go back to back,
  // others get random gaps between beats
  task automatic send_line();
    bit          gappy;
    int unsigned gap;
    gappy = ($urandom_range(0, 9) >= 3);
    line_buf.push_back(CH_NL);
    foreach (line_buf[i]) begin
      if (gappy && $urandom_range(0, 99) < 25) begin
        gap = pick_gap();
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_rx_byte <= line_buf[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent_bytes++;
    end
    line_buf.delete();
  endtask

  // record sink: out_ready stalls at a randomly redrawn rate,
  // zero included so there are stretches with no back-pressure at all
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 10;
        2: stall_pct <= 40;
        default: stall_pct <= 75;
      endcase
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= pick_gap() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    // watchdog
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_start;
    int unsigned kind;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines
    send_line();                                   // empty line
    put_str("T:1,2,3;L:4,5,6");
    send_line();
    put_str("T:32767,-32768,0;L:99999,-99999,+12"); // limits and saturation
    send_line();
    put_str("T:0;L:0");
    send_line();
    put_str("T:");                                 // every blank kind before a number
    put_byte(CH_SPACE);
    put_byte(CH_TAB);
    put_byte(CH_VT);
    put_byte(CH_FF);
    put_byte(CH_CR);
    put_str("-17,0007, ;L:x,+,-");                 // tokens with no digits give zero
    send_line();
    put_str("T:+-5,--3,4x9;L:12 34,5.5,-0");
    send_line();
    put_str("T:9,9,9");                            // second part missing
    send_line();
    put_str("X:1,2,3;L:7,8,9");                    // bad target tag
    send_line();
    put_str("T:1,2,3;T:4,5,6");                    // bad laser tag
    send_line();
    put_str(";;T:,,,21,,,22,23,24,25;;;L:31,32;Q:99"); // separator runs, extra token/part
    send_line();
    put_str("T-5;L5:6");
    send_line();
    put_str("T:5");                                // nul before the second part
    put_byte(CH_NUL);
    put_str(",6;L:7");
    send_line();
    put_str("T:1;L:2,3,4");                        // nul after both parts
    put_byte(CH_NUL);
    put_str(";Q");
    send_line();
    put_str("T:-99999;L:123456789");
    send_line();
    put_str("T:");                                 // high bytes in the fields
    put_byte(8'hFF);
    put_str(",5;L:");
    put_byte(8'h80);
    put_str("6,");
    put_byte(8'h7F);
    send_line();
    put_str("T:11;L:22");                          // longest line that still counts
    put_fill(CH_SPACE, 117);
    send_line();
    put_fill("z", 127);                            // dropped, then a fresh line follows
    put_str("T:1;L:2");
    send_line();

    // random lines
    random_start = sent_bytes;
    while (sent_bytes < random_start + RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // well formed record with random content
        put_part("T:", field_total());
        repeat (($urandom_range(0, 7) == 0) ? 2 : 1) put_byte(CH_SEMI);
        put_part("L:", field_total());
        if ($urandom_range(0, 9) == 0) begin
          put_byte(CH_SEMI);
          put_part("T:", field_total());
        end
      end else if (kind < 85) begin
        case ($urandom_range(0, 4))
          0: put_part("T:", field_total());
          1: begin
            put_part("L:", 3);
            put_byte(CH_SEMI);
            put_part("T:", 3);
          end
          2: begin
            put_part("T:", $urandom_range(1, 3));
            put_byte(CH_NUL);
            if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(0, 255)));
            put_byte(CH_SEMI);
            put_part("L:", 3);
          end
          3: begin
            put_part($sformatf("%c%c", $urandom_range(65, 90), $urandom_range(48, 90)), 3);
            put_byte(CH_SEMI);
            put_part("L:", 3);
          end
          default: begin
            // lone newline
          end
        endcase
      end else if (kind < 95) begin
        // raw noise over the whole byte range
        repeat ($urandom_range(1, 30)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        // padded record straddling the line length limit
        put_part("T:", 3);
        put_byte(CH_SEMI);
        put_part("L:", 3);
        put_fill(blank_set[$urandom_range(0, 4)], $urandom_range(95, 125));
      end
      send_line();
    end
    in_valid <= 1'b0;

    // drain the owed records, then wait a little longer for strays
    while (records_owed != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== target_laser_line_parser.f =====
hw/rtl/tlp_pkg.sv
hw/rtl/target_laser_line_parser.sv
tb/sv/tlp_line_checker.sv
tb/sv/target_laser_line_parser_test.sv
